FILE: hdl/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// RGBE scanline decoder package
// Request/response types, decode modes and status codes.
// ----------------------------------------------------------------------------
package rgbe_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} rgbe_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  exponent;
		logic [11:0] column;
		logic [15:0] row;
		logic        last_of_image;
	} rgbe_out_t;

	// scanline store plane depth (pixels per plane)
	localparam int MAX_WIDTH = 4096;

	localparam logic FUNC_PUSH = 1'b0;

	localparam logic [2:0] ST_TAKEN   = 3'd0;
	localparam logic [2:0] ST_PIXEL   = 3'd1;
	localparam logic [2:0] ST_REFUSED = 3'd2;
	localparam logic [2:0] ST_ERROR   = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	localparam logic [2:0] MODE_GATHER  = 3'd0;
	localparam logic [2:0] MODE_COUNT   = 3'd1;
	localparam logic [2:0] MODE_RUNVAL  = 3'd2;
	localparam logic [2:0] MODE_LITERAL = 3'd3;
	localparam logic [2:0] MODE_DRAIN   = 3'd4;
	localparam logic [2:0] MODE_FLAT    = 3'd5;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [15:0] FLAT_MAX_WIDTH = 16'h7fff;
	localparam logic [7:0]  RUN_FLAG       = 8'd128;
	localparam logic [7:0]  HDR_MARK       = 8'd2;
	localparam logic [12:0] MIN_CODED_W    = 13'd8;

endpackage

FILE: hdl/rgbe_scanline_rle_decoder.sv
// ----------------------------------------------------------------------------
// RGBE scanline RLE decoder
// Decodes Radiance HDR pixel-data bytes into RGBE pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per item; func selects push of a stream byte or
//            pull of the next pixel. Exactly one response per request.
//   out_*  : response with status and, for a pixel, its RGBE bytes and
//            position. Output register holds it until taken.
//   cfg_*  : register writes (0 image_width, 1 image_height), only while idle.
// Timing: a push is answered in the cycle after acceptance. A pull passes
// through busy_q, the registered store read (rd_s1) and the output
// register. A run value is answered after the run has written the scanline
// store one entry per cycle. The held response blocks the input, so no
// request is taken until the last response is taken. The store is four
// byte-wide RAMs, one per channel, single write port and registered read.
// Reset clears all control state; store contents are undefined until written.
// When the receiver stalls, the held response blocks further requests.
// ----------------------------------------------------------------------------
module rgbe_scanline_rle_decoder
	import rgbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rgbe_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output rgbe_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  mode_q;
	logic [23:0] group_q;
	logic [1:0]  fill_q;
	logic [1:0]  chan_q;
	logic [12:0] pos_q;
	logic [7:0]  lit_q;
	logic [7:0]  run_q;
	logic [7:0]  runval_q;
	logic        filling_q;
	logic [12:0] drain_q;
	logic [15:0] row_q;
	logic        flat_q;
	logic        err_q;
	logic        busy_q;
	logic        rd_s1;
	logic [12:0] rd_col_s1;
	logic [15:0] rd_row_s1;
	logic        rd_last_s1;

	logic [7:0] mem0 [MAX_WIDTH];
	logic [7:0] mem1 [MAX_WIDTH];
	logic [7:0] mem2 [MAX_WIDTH];
	logic [7:0] mem3 [MAX_WIDTH];
	logic [7:0] rdat [4];

	logic          we;
	logic [3:0]    we_lane;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;

	logic       acc;
	logic [7:0] b;
	logic [12:0] room;
	logic [15:0] hdr_w;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q && !filling_q && !rd_s1 && !out_valid;
	assign acc = in_valid && in_ready;
	assign b   = in_data.data_byte;
	assign room = (width_q > pos_q) ? width_q - pos_q : 13'd0;
	assign hdr_w = {group_q[7:0], b};

	// store access
	always_comb begin
		we = 1'b0;
		we_lane = 4'b0;
		waddr = '0;
		wdata = b;
		re = 1'b0;
		raddr = '0;
		if (filling_q) begin
			we = 1'b1;
			we_lane = 4'b1 << chan_q;
			waddr = pos_q[AW-1:0];
			wdata = runval_q;
		end else if (busy_q) begin
			re = 1'b1;
			raddr = (mode_q == MODE_DRAIN) ? drain_q[AW-1:0] : '0;
		end else if (acc && !err_q && width_q != 0 && row_q < height_q
				&& in_data.func == FUNC_PUSH) begin
			if (mode_q == MODE_LITERAL) begin
				we = 1'b1;
				we_lane = 4'b1 << chan_q;
				waddr = pos_q[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && we_lane[0]) mem0[waddr] <= wdata;
		if (we && we_lane[1]) mem1[waddr] <= wdata;
		if (we && we_lane[2]) mem2[waddr] <= wdata;
		if (we && we_lane[3]) mem3[waddr] <= wdata;
		if (re) begin
			rdat[0] <= mem0[raddr];
			rdat[1] <= mem1[raddr];
			rdat[2] <= mem2[raddr];
			rdat[3] <= mem3[raddr];
		end
	end

	// flat pixel lives in its own register (flat_pix_q), not store
	logic [31:0] flat_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1;
			height_q <= 16'd1;
			mode_q <= MODE_GATHER;
			group_q <= '0;
			fill_q <= '0;
			chan_q <= '0;
			pos_q <= '0;
			lit_q <= '0;
			run_q <= '0;
			filling_q <= 1'b0;
			drain_q <= '0;
			row_q <= '0;
			flat_q <= 1'b0;
			err_q <= 1'b0;
			busy_q <= 1'b0;
			rd_s1 <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_WIDTH) width_q <= cfg_data[12:0];
				else height_q <= cfg_data;
			end
			if (out_valid && out_ready) out_valid <= 1'b0;

			if (filling_q) begin
				pos_q <= pos_q + 13'd1;
				run_q <= run_q - 8'd1;
				if (run_q == 8'd1) begin
					filling_q <= 1'b0;
					out_valid <= 1'b1;
					out_data <= '0;
					out_data.status <= ST_TAKEN;
					mode_q <= MODE_COUNT;
					if (pos_q + 13'd1 >= width_q) begin
						pos_q <= '0;
						if (chan_q == 2'd3) begin
							chan_q <= '0;
							drain_q <= '0;
							mode_q <= MODE_DRAIN;
						end else chan_q <= chan_q + 2'd1;
					end
				end
			end

			if (busy_q) begin
				busy_q <= 1'b0;
				rd_s1 <= 1'b1;
				rd_col_s1 <= drain_q;
				rd_row_s1 <= row_q;
				rd_last_s1 <= (row_q + 16'd1 >= height_q) && (drain_q + 13'd1 >= width_q);
				if (drain_q + 13'd1 >= width_q) begin
					drain_q <= '0;
					row_q <= row_q + 16'd1;
					mode_q <= MODE_GATHER;
				end else begin
					drain_q <= drain_q + 13'd1;
					if (mode_q == MODE_FLAT) mode_q <= MODE_GATHER;
				end
			end

			if (rd_s1) begin
				rd_s1 <= 1'b0;
				out_valid <= 1'b1;
				out_data.status <= ST_PIXEL;
				out_data.red <= flat_q ? flat_pix_q[31:24] : rdat[0];
				out_data.green <= flat_q ? flat_pix_q[23:16] : rdat[1];
				out_data.blue <= flat_q ? flat_pix_q[15:8] : rdat[2];
				out_data.exponent <= flat_q ? flat_pix_q[7:0] : rdat[3];
				out_data.column <= rd_col_s1[11:0];
				out_data.row <= rd_row_s1;
				out_data.last_of_image <= rd_last_s1;
			end

			if (acc) begin
				out_data <= '0;
				out_valid <= 1'b1;
				if (err_q) out_data.status <= ST_ERROR;
				else if (width_q == 0 || row_q >= height_q) out_data.status <= ST_DONE;
				else if (in_data.func == FUNC_PUSH) begin
					out_data.status <= ST_TAKEN;
					case (mode_q)
						MODE_GATHER: begin
							if (fill_q != 2'd3) begin
								group_q <= {group_q[15:0], b};
								fill_q <= fill_q + 2'd1;
							end else begin
								group_q <= '0;
								fill_q <= '0;
								if (flat_q || width_q < MIN_CODED_W
										|| {3'b0, width_q} > FLAT_MAX_WIDTH
										|| group_q[23:16] != HDR_MARK
										|| group_q[15:8] != HDR_MARK || group_q[7]) begin
									flat_q <= 1'b1;
									flat_pix_q <= {group_q, b};
									mode_q <= MODE_FLAT;
								end else if (hdr_w != {3'b0, width_q}
										|| {3'b0, width_q} > 16'(MAX_WIDTH)) begin
									err_q <= 1'b1;
									out_data.status <= ST_ERROR;
								end else begin
									chan_q <= '0;
									pos_q <= '0;
									mode_q <= MODE_COUNT;
								end
							end
						end
						MODE_COUNT: begin
							if (b > RUN_FLAG) begin
								if ({5'b0, b - RUN_FLAG} > room) begin
									err_q <= 1'b1;
									out_data.status <= ST_ERROR;
								end else begin
									run_q <= b - RUN_FLAG;
									mode_q <= MODE_RUNVAL;
								end
							end else if (b == 8'd0 || {5'b0, b} > room) begin
								err_q <= 1'b1;
								out_data.status <= ST_ERROR;
							end else begin
								lit_q <= b;
								mode_q <= MODE_LITERAL;
							end
						end
						MODE_RUNVAL: begin
							// run of count entries, one write per cycle
							runval_q <= b;
							filling_q <= 1'b1;
							out_valid <= 1'b0;
						end
						MODE_LITERAL: begin
							pos_q <= pos_q + 13'd1;
							lit_q <= lit_q - 8'd1;
							if (lit_q == 8'd1) begin
								mode_q <= MODE_COUNT;
								if (pos_q + 13'd1 >= width_q) begin
									pos_q <= '0;
									if (chan_q == 2'd3) begin
										chan_q <= '0;
										drain_q <= '0;
										mode_q <= MODE_DRAIN;
									end else chan_q <= chan_q + 2'd1;
								end
							end
						end
						default: out_data.status <= ST_REFUSED;
					endcase
				end else begin
					if (mode_q == MODE_DRAIN || mode_q == MODE_FLAT) begin
						busy_q <= 1'b1;
						out_valid <= 1'b0;
					end else out_data.status <= ST_REFUSED;
				end
			end
		end
	end

endmodule
